// ----- rtl/double_ended_queue_engine_macros.svh -----
// -----------------------------------------------------------------------------
// Double-ended queue engine: assertion macros
// Shared forms for the concurrent checks in the RTL.
// -----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_ENGINE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_ENGINE_MACROS_SVH

// Checked on every rising edge of clk while arst_n is high.
`define DEQ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising edge of clk, also during reset.
`define DEQ_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/deq_pkg.sv -----
// -----------------------------------------------------------------------------
// Double-ended queue engine package
// Command and status codes, cell actions and the operation bundle to the cells.
// -----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

	localparam int DATA_W      = 32;
	localparam int CMD_W       = 3;
	localparam int STATUS_W    = 2;
	localparam int COUNT_OUT_W = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_PLACE      = 3'd4
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// What one chain of cells does in a cycle.
	typedef enum logic [1:0] {
		ACT_HOLD   = 2'd0,
		ACT_PUSH   = 2'd1,
		ACT_POP    = 2'd2,
		ACT_APPEND = 2'd3
	} act_t;

	typedef struct packed {
		act_t              act_a;
		act_t              act_b;
		logic [DATA_W-1:0] value;
	} op_t;

endpackage

`default_nettype wire

// ----- rtl/deq_if.sv -----
// -----------------------------------------------------------------------------
// Double-ended queue engine channels
// Valid/ready interfaces for the command and the result channel.
// -----------------------------------------------------------------------------
`default_nettype none

interface deq_in_if;
	logic                                valid;
	logic                                ready;
	logic [deq_pkg::CMD_W-1:0]           cmd;
	logic signed [deq_pkg::DATA_W-1:0]   value;

	modport source (output valid, output cmd, output value, input ready);
	modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface deq_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [deq_pkg::DATA_W-1:0]    popped_value;
	logic [deq_pkg::STATUS_W-1:0]         status;
	logic [deq_pkg::COUNT_OUT_W-1:0]      count_after;

	modport source (output valid, output popped_value, output status, output count_after,
		input ready);
	modport sink   (input valid, input popped_value, input status, input count_after,
		output ready);
endinterface

`default_nettype wire

// ----- rtl/double_ended_queue_engine.sv -----
// Double-ended queue engine, DEPTH signed 32-bit entries.
// Channel req carries one command word (cmd, value); channel rsp returns one
// result word (popped_value, status, count_after) for every command word.
// Commands: push front, push back, pop front, pop back, and place, which goes
// to the front when the value is below the current front entry, else to the back.
// Pops on an empty queue give status 1 and value 0; pushes on a full queue drop
// the value and give status 2.
// rsp.valid rises in the cycle after acceptance; one word is accepted per cycle
// unless a result waits with rsp.ready low, set by the cell rows and result register.
// The entries sit in two rows of DEPTH cells, one ordered from the front and
// one from the back; a push or pop shifts one row toward or away from cell 0.
// Reset clears the entry count and the result valid flag; the cells and the
// result word are not reset. While a result waits with rsp.ready low,
// req.ready is low and the queue holds its state; the result is taken in the
// cycle rsp.ready rises and a new command can be accepted in that same cycle.
// -----------------------------------------------------------------------------
// Double-ended queue engine top level
// Cell rows of the queue and the command controller.
// -----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue_engine #(
	parameter int DEPTH = 16
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	deq_in_if.sink       req,
	deq_out_if.source    rsp
);

	localparam int CW = $clog2(DEPTH+1);

	deq_pkg::op_t                op;
	logic [CW-1:0]               count;
	logic [deq_pkg::DATA_W-1:0]  a_bus [DEPTH];
	logic [deq_pkg::DATA_W-1:0]  b_bus [DEPTH];

	deq_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.front_val (a_bus[0]),
		.back_val  (b_bus[0]),
		.op        (op),
		.count     (count)
	);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [deq_pkg::DATA_W-1:0] a_left;
		logic [deq_pkg::DATA_W-1:0] a_right;
		logic [deq_pkg::DATA_W-1:0] b_left;
		logic [deq_pkg::DATA_W-1:0] b_right;

		if (i == 0) begin : g_head
			assign a_left = op.value;
			assign b_left = op.value;
		end else begin : g_body
			assign a_left = a_bus[i-1];
			assign b_left = b_bus[i-1];
		end

		if (i == DEPTH-1) begin : g_tail
			assign a_right = '0;
			assign b_right = '0;
		end else begin : g_inner
			assign a_right = a_bus[i+1];
			assign b_right = b_bus[i+1];
		end

		deq_cell #(
			.DEPTH(DEPTH),
			.IDX  (i)
		) u_cell (
			.clk     (clk),
			.op      (op),
			.count   (count),
			.a_left  (a_left),
			.a_right (a_right),
			.b_left  (b_left),
			.b_right (b_right),
			.a       (a_bus[i]),
			.b       (b_bus[i])
		);
	end

endmodule

`default_nettype wire

// ----- rtl/deq_cell.sv -----
// -----------------------------------------------------------------------------
// Double-ended queue cell
// Holds one entry of the front-ordered chain and one of the back-ordered chain.
// -----------------------------------------------------------------------------
`default_nettype none

module deq_cell #(
	parameter int DEPTH = 16,
	parameter int IDX   = 0
) (
	input  wire logic                          clk,
	input  wire deq_pkg::op_t                  op,
	input  wire logic [$clog2(DEPTH+1)-1:0]    count,
	input  wire logic [deq_pkg::DATA_W-1:0]    a_left,
	input  wire logic [deq_pkg::DATA_W-1:0]    a_right,
	input  wire logic [deq_pkg::DATA_W-1:0]    b_left,
	input  wire logic [deq_pkg::DATA_W-1:0]    b_right,
	output logic [deq_pkg::DATA_W-1:0]         a,
	output logic [deq_pkg::DATA_W-1:0]         b
);

	localparam int CW = $clog2(DEPTH+1);
	localparam logic [CW-1:0] IDX_C = CW'(IDX);

	logic [deq_pkg::DATA_W-1:0] a_q;
	logic [deq_pkg::DATA_W-1:0] b_q;
	logic                       at_count;

	assign at_count = (count == IDX_C);

	// A push shifts the chain away from cell 0, a pop shifts it toward cell 0,
	// and an append writes only the cell just past the last stored entry.
	always_ff @(posedge clk) begin
		case (op.act_a)
			deq_pkg::ACT_PUSH: a_q <= a_left;
			deq_pkg::ACT_POP: a_q <= a_right;
			deq_pkg::ACT_APPEND: begin
				if (at_count) a_q <= op.value;
			end
			default: ;
		endcase
		case (op.act_b)
			deq_pkg::ACT_PUSH: b_q <= b_left;
			deq_pkg::ACT_POP: b_q <= b_right;
			deq_pkg::ACT_APPEND: begin
				if (at_count) b_q <= op.value;
			end
			default: ;
		endcase
	end

	assign a = a_q;
	assign b = b_q;

endmodule

`default_nettype wire

// ----- rtl/deq_ctrl.sv -----
// -----------------------------------------------------------------------------
// Double-ended queue controller
// Decodes commands, keeps the entry count and registers the result word.
// -----------------------------------------------------------------------------
`default_nettype none

`include "double_ended_queue_engine_macros.svh"

module deq_ctrl #(
	parameter int DEPTH = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	deq_in_if.sink                             req,
	deq_out_if.source                          rsp,
	input  wire logic [deq_pkg::DATA_W-1:0]    front_val,
	input  wire logic [deq_pkg::DATA_W-1:0]    back_val,
	output deq_pkg::op_t                       op,
	output logic [$clog2(DEPTH+1)-1:0]         count
);

	localparam int CW = $clog2(DEPTH+1);
	localparam logic [CW-1:0] FULL_C = CW'(DEPTH);

	logic [CW-1:0]                  count_q;
	logic [CW-1:0]                  count_next;
	logic                           out_valid_q;
	logic [deq_pkg::DATA_W-1:0]     popped_q;
	deq_pkg::status_t               status_q;
	logic [deq_pkg::COUNT_OUT_W-1:0] count_after_q;

	logic                           fire;
	logic                           empty;
	logic                           full;
	logic                           go_front;
	deq_pkg::act_t                  act_a;
	deq_pkg::act_t                  act_b;
	deq_pkg::status_t               status_d;
	logic [deq_pkg::DATA_W-1:0]     popped_d;
	logic [CW+deq_pkg::COUNT_OUT_W-1:0] count_ext;

	assign req.ready = !out_valid_q || rsp.ready;
	assign fire      = req.valid && req.ready;
	assign empty     = (count_q == '0);
	assign full      = (count_q == FULL_C);
	assign go_front  = !empty && ($signed(req.value) < $signed(front_val));

	// Chain a keeps the front entry in cell 0, chain b keeps the back entry there.
	always_comb begin
		act_a      = deq_pkg::ACT_HOLD;
		act_b      = deq_pkg::ACT_HOLD;
		status_d   = deq_pkg::ST_OK;
		popped_d   = '0;
		count_next = count_q;
		unique case (deq_pkg::cmd_t'(req.cmd))
			deq_pkg::CMD_PUSH_FRONT: begin
				if (full) begin
					status_d = deq_pkg::ST_FULL;
				end else begin
					act_a      = deq_pkg::ACT_PUSH;
					act_b      = deq_pkg::ACT_APPEND;
					count_next = count_q + CW'(1);
				end
			end
			deq_pkg::CMD_PUSH_BACK: begin
				if (full) begin
					status_d = deq_pkg::ST_FULL;
				end else begin
					act_a      = deq_pkg::ACT_APPEND;
					act_b      = deq_pkg::ACT_PUSH;
					count_next = count_q + CW'(1);
				end
			end
			deq_pkg::CMD_POP_FRONT: begin
				if (empty) begin
					status_d = deq_pkg::ST_EMPTY;
				end else begin
					popped_d   = front_val;
					act_a      = deq_pkg::ACT_POP;
					count_next = count_q - CW'(1);
				end
			end
			deq_pkg::CMD_POP_BACK: begin
				if (empty) begin
					status_d = deq_pkg::ST_EMPTY;
				end else begin
					popped_d   = back_val;
					act_b      = deq_pkg::ACT_POP;
					count_next = count_q - CW'(1);
				end
			end
			deq_pkg::CMD_PLACE: begin
				if (full) begin
					status_d = deq_pkg::ST_FULL;
				end else if (go_front) begin
					act_a      = deq_pkg::ACT_PUSH;
					act_b      = deq_pkg::ACT_APPEND;
					count_next = count_q + CW'(1);
				end else begin
					act_a      = deq_pkg::ACT_APPEND;
					act_b      = deq_pkg::ACT_PUSH;
					count_next = count_q + CW'(1);
				end
			end
			default: ;
		endcase
	end

	assign op.act_a = fire ? act_a : deq_pkg::ACT_HOLD;
	assign op.act_b = fire ? act_b : deq_pkg::ACT_HOLD;
	assign op.value = req.value;
	assign count    = count_q;

	assign count_ext = {{deq_pkg::COUNT_OUT_W{1'b0}}, count_next};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			popped_q      <= popped_d;
			status_q      <= status_d;
			count_after_q <= count_ext[deq_pkg::COUNT_OUT_W-1:0];
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.popped_value = popped_q;
	assign rsp.status       = status_q;
	assign rsp.count_after  = count_after_q;

	`DEQ_ASSERT(a_count_bound, count_q <= FULL_C, "entry count above depth")
	`DEQ_ASSERT(a_count_idle, !fire |=> $stable(count_q), "count moved without an accepted word")
	`DEQ_ASSERT(a_result_follows, fire |=> rsp.valid, "accepted word gave no result")
	`DEQ_ASSERT(a_full_status, (out_valid_q && status_q == deq_pkg::ST_FULL) |-> full, "full status with room left")
	`DEQ_ASSERT(a_empty_status, (out_valid_q && status_q == deq_pkg::ST_EMPTY) |-> (empty && popped_q == '0), "empty status on a non-empty queue")

endmodule

`default_nettype wire
